[src/rksc_pkg.sv]
// package for the rotary knob setpoint control block
// register indexes, input kinds, field widths, timing constants and reset values; no dependencies
`default_nettype none
package rksc_pkg;

    localparam int SP_W    = 16;
    localparam int STEP_W  = 10;
    localparam int HOLD_W  = 13;
    localparam int PRESS_W = 12;
    localparam int TICK_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_EDGE   = 2'd1,
        KIND_WINDOW = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT_MIN   = 3'd0,
        REG_SETPOINT_MAX   = 3'd1,
        REG_FAST_THRESHOLD = 3'd2,
        REG_FINE_STEP      = 3'd3,
        REG_COARSE_STEP    = 3'd4,
        REG_HOLD_RUNNING   = 3'd5,
        REG_HOLD_STOPPED   = 3'd6,
        REG_UNUSED         = 3'd7
    } t_cfg_idx;

    localparam logic [PRESS_W-1:0] SHORT_LOW_MS  = 12'd100;
    localparam logic [PRESS_W-1:0] LONG_START_MS = 12'd1500;
    localparam logic [PRESS_W-1:0] LONG_END_MS   = 12'd3000;
    localparam logic [PRESS_W-1:0] PRESS_MAX     = 12'd4095;

    localparam logic [SP_W-1:0]   RST_SETPOINT_MIN   = 16'd0;
    localparam logic [SP_W-1:0]   RST_SETPOINT_MAX   = 16'd65535;
    localparam logic [SP_W-1:0]   RST_FAST_THRESHOLD = 16'd60;
    localparam logic [STEP_W-1:0] RST_FINE_STEP      = 10'd10;
    localparam logic [STEP_W-1:0] RST_COARSE_STEP    = 10'd30;
    localparam logic [HOLD_W-1:0] RST_HOLD_RUNNING   = 13'd4000;
    localparam logic [HOLD_W-1:0] RST_HOLD_STOPPED   = 13'd2000;

endpackage
`default_nettype wire

[src/rotary_knob_setpoint_control_top.sv]
// Rotary knob setpoint control: one beat in, one result beat out per item, one item
// per clock cycle sustained while the output takes results. An accepted beat sits
// in an input register; once the output register can take it, its kind (tick,
// encoder edge, speed window end) updates the knob, hold timer and button state in
// one pass of logic and the result lands in the output register. Both registers
// keep moving while the output waits until they fill. Configuration registers are
// written through i_cfg_* only while no item is in flight, a rule for the user
// not enforced by the block. No clearing pass after reset. depends on rksc_pkg
`default_nettype none
module rotary_knob_setpoint_control_top
    import rksc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [7:0] tick_ms, [8] button_down, [9] dir_level, [10] running, [15:11] zero
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] kind
    input  wire logic [1:0]            s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [15:0] setpoint, [16] commit, [17] beep, [18] start_request,
    // [19] stop_request, [20] long_press, [21] knob_active, [23:22] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    // configuration
    logic [SP_W-1:0]   r_sp_min, r_sp_max, r_fast_thr;
    logic [STEP_W-1:0] r_fine_step, r_coarse_step;
    logic [HOLD_W-1:0] r_hold_run, r_hold_stop;

    // knob and button state
    logic [SP_W-1:0]    r_setpoint, n_setpoint;
    logic [SP_W-1:0]    r_edge_cnt, n_edge_cnt;
    logic [SP_W-1:0]    r_turn_rate, n_turn_rate;
    logic [HOLD_W-1:0]  r_hold, n_hold;
    logic [PRESS_W-1:0] r_press_time, n_press_time;
    logic               r_press_seen, n_press_seen;
    logic               r_long, n_long;

    // input register
    logic              r_in_valid;
    t_kind             r_kind;
    logic [TICK_W-1:0] r_tick;
    logic              r_down, r_dec, r_run;

    // output register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic advance;
    logic n_commit, n_beep, n_start, n_stop;

    // temporaries
    logic [HOLD_W-1:0]  tick_ext;
    logic [PRESS_W:0]   press_sum;
    logic [SP_W-1:0]    step;
    logic [SP_W:0]      sp_up;
    logic [SP_W-1:0]    sp_dn;
    logic [SP_W+1:0]    rate_x3;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp_min      <= RST_SETPOINT_MIN;
            r_sp_max      <= RST_SETPOINT_MAX;
            r_fast_thr    <= RST_FAST_THRESHOLD;
            r_fine_step   <= RST_FINE_STEP;
            r_coarse_step <= RST_COARSE_STEP;
            r_hold_run    <= RST_HOLD_RUNNING;
            r_hold_stop   <= RST_HOLD_STOPPED;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_SETPOINT_MIN:   r_sp_min      <= i_cfg_wdata;
                REG_SETPOINT_MAX:   r_sp_max      <= i_cfg_wdata;
                REG_FAST_THRESHOLD: r_fast_thr    <= i_cfg_wdata;
                REG_FINE_STEP:      r_fine_step   <= i_cfg_wdata[STEP_W-1:0];
                REG_COARSE_STEP:    r_coarse_step <= i_cfg_wdata[STEP_W-1:0];
                REG_HOLD_RUNNING:   r_hold_run    <= i_cfg_wdata[HOLD_W-1:0];
                REG_HOLD_STOPPED:   r_hold_stop   <= i_cfg_wdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_setpoint   = r_setpoint;
        n_edge_cnt   = r_edge_cnt;
        n_turn_rate  = r_turn_rate;
        n_hold       = r_hold;
        n_press_time = r_press_time;
        n_press_seen = r_press_seen;
        n_long       = r_long;
        n_commit     = 1'b0;
        n_beep       = 1'b0;
        n_start      = 1'b0;
        n_stop       = 1'b0;

        tick_ext  = {{(HOLD_W-TICK_W){1'b0}}, r_tick};
        press_sum = {1'b0, r_press_time} + {{(PRESS_W+1-TICK_W){1'b0}}, r_tick};
        step      = (r_turn_rate < r_fast_thr) ? {{(SP_W-STEP_W){1'b0}}, r_fine_step}
                                               : {{(SP_W-STEP_W){1'b0}}, r_coarse_step};
        sp_up     = {1'b0, r_setpoint} + {1'b0, step};
        sp_dn     = r_setpoint - step;
        rate_x3   = {2'b00, r_edge_cnt} + {1'b0, r_edge_cnt, 1'b0};

        case (r_kind)
            KIND_TICK: begin
                if (r_hold != '0 && r_tick != '0) begin
                    if (tick_ext >= r_hold) begin
                        n_hold   = '0;
                        n_commit = 1'b1;
                        n_beep   = r_run;
                    end else begin
                        n_hold = r_hold - tick_ext;
                    end
                end
                if (r_down && !r_long) begin
                    n_press_time = press_sum[PRESS_W] ? PRESS_MAX : press_sum[PRESS_W-1:0];
                    n_press_seen = 1'b1;
                end
                if (n_press_seen) begin
                    if (!r_down) begin
                        if (n_press_time > SHORT_LOW_MS && n_press_time < LONG_START_MS) begin
                            n_stop  = r_run;
                            n_start = !r_run;
                            n_beep  = 1'b1;
                        end
                        n_press_seen = 1'b0;
                        n_long       = 1'b0;
                        n_press_time = '0;
                    end else if (n_press_time > LONG_START_MS &&
                                 n_press_time < LONG_END_MS) begin
                        n_long = 1'b1;
                    end
                end
            end
            KIND_EDGE: begin
                if (r_edge_cnt != '1) begin
                    n_edge_cnt = r_edge_cnt + 1'b1;
                end
                n_hold = r_run ? r_hold_run : r_hold_stop;
                if (r_dec) begin
                    // underflow counts as below the floor
                    if (step >= r_setpoint || sp_dn <= r_sp_min) begin
                        n_setpoint = r_sp_min;
                    end else begin
                        n_setpoint = sp_dn;
                    end
                end else begin
                    n_setpoint = (sp_up > {1'b0, r_sp_max}) ? r_sp_max : sp_up[SP_W-1:0];
                end
            end
            KIND_WINDOW: begin
                n_turn_rate = (rate_x3[SP_W+1:SP_W] != 2'b00) ? '1 : rate_x3[SP_W-1:0];
                n_edge_cnt  = '0;
            end
            default: ;
        endcase

        n_out_data = {2'b00, (n_hold != '0), n_long, n_stop, n_start, n_beep, n_commit,
                      n_setpoint};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_setpoint   <= '0;
            r_edge_cnt   <= '0;
            r_turn_rate  <= '0;
            r_hold       <= '0;
            r_press_time <= '0;
            r_press_seen <= 1'b0;
            r_long       <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_setpoint   <= n_setpoint;
                r_edge_cnt   <= n_edge_cnt;
                r_turn_rate  <= n_turn_rate;
                r_hold       <= n_hold;
                r_press_time <= n_press_time;
                r_press_seen <= n_press_seen;
                r_long       <= n_long;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_kind <= t_kind'(s_axis_tuser);
            r_tick <= s_axis_tdata[TICK_W-1:0];
            r_down <= s_axis_tdata[TICK_W];
            r_dec  <= s_axis_tdata[TICK_W+1];
            r_run  <= s_axis_tdata[TICK_W+2];
        end
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

endmodule
`default_nettype wire

[bench/tb_rotary_knob_setpoint_control_top.sv]
// testbench for rotary_knob_setpoint_control_top: drives tick, edge, window and no-kind beats,
// predicts every result beat in a local knob model and checks it field by field
// depends on rksc_pkg and the rotary_knob_setpoint_control_top rtl
`timescale 1ns / 100ps
module tb_rotary_knob_setpoint_control_top;
    import rksc_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int CHUNKS       = 16;
    localparam int CHUNK_ITEMS  = 102;
    localparam int REPORT_LINES = 100;

    typedef struct packed {
        t_kind             kind;
        logic [TICK_W-1:0] tick;
        logic              down;
        logic              dir;
        logic              run;
    } t_knob_item;

    // field order matches the result beat from the top bit down
    typedef struct packed {
        logic            knob_active;
        logic            long_press;
        logic            stop_request;
        logic            start_request;
        logic            beep;
        logic            commit;
        logic [SP_W-1:0] setpoint;
    } t_knob_result;

    typedef struct {
        logic [SP_W-1:0]   lo;
        logic [SP_W-1:0]   hi;
        logic [SP_W-1:0]   thr;
        logic [STEP_W-1:0] fine;
        logic [STEP_W-1:0] coarse;
        logic [HOLD_W-1:0] hrun;
        logic [HOLD_W-1:0] hstop;
    } t_knob_cfg;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [7:0] tick_ms, [8] button_down,
                                                 // [9] dir_level, [10] running
    logic [1:0]            s_axis_tuser = '0;   // [1:0] kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // [15:0] setpoint, [16] commit, [17] beep,
                                                 // [18] start_request, [19] stop_request,
                                                 // [20] long_press, [21] knob_active

    rotary_knob_setpoint_control_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // knob model state and its copy of the registers
    logic [SP_W-1:0]    knob_sp, knob_edges, knob_rate;
    logic [HOLD_W-1:0]  knob_hold;
    logic [PRESS_W-1:0] knob_press;
    logic               knob_pressed, knob_long;
    logic [SP_W-1:0]    lim_min, lim_max, rate_thr;
    logic [STEP_W-1:0]  step_fine, step_coarse;
    logic [HOLD_W-1:0]  hold_run, hold_stop;

    t_knob_item   items_to_send[$];
    t_knob_result knob_results_due[$];
    t_knob_item   item_on_bus;
    int           err_count = 0;
    int           send_gap = 0;
    int           recv_stall = 0;
    int           idle_cycles = 0;
    bit           quiet = 1'b0;
    bit           gen_btn = 1'b0;
    bit           gen_run = 1'b0;

    function automatic void reset_knob();
        knob_sp      = '0;
        knob_edges   = '0;
        knob_rate    = '0;
        knob_hold    = '0;
        knob_press   = '0;
        knob_pressed = 1'b0;
        knob_long    = 1'b0;
        lim_min      = RST_SETPOINT_MIN;
        lim_max      = RST_SETPOINT_MAX;
        rate_thr     = RST_FAST_THRESHOLD;
        step_fine    = RST_FINE_STEP;
        step_coarse  = RST_COARSE_STEP;
        hold_run     = RST_HOLD_RUNNING;
        hold_stop    = RST_HOLD_STOPPED;
    endfunction

    // one accepted beat: update the knob model and queue the result it causes
    function automatic void advance_knob(t_knob_item it);
        t_knob_result res;
        int unsigned  step, sum, prod;
        res = '0;
        case (it.kind)
            KIND_TICK: begin
                if (knob_hold != 0 && it.tick != 0) begin
                    if (it.tick >= knob_hold)
                        knob_hold = '0;
                    else
                        knob_hold = knob_hold - it.tick;
                    if (knob_hold == 0) begin
                        res.commit = 1'b1;
                        res.beep   = it.run;
                    end
                end
                if (it.down && !knob_long) begin
                    sum          = knob_press + it.tick;
                    knob_press   = (sum > PRESS_MAX) ? PRESS_MAX : sum[PRESS_W-1:0];
                    knob_pressed = 1'b1;
                end
                if (knob_pressed) begin
                    if (!it.down) begin
                        if (knob_press > SHORT_LOW_MS && knob_press < LONG_START_MS) begin
                            res.stop_request  = it.run;
                            res.start_request = !it.run;
                            res.beep          = 1'b1;
                        end
                        knob_pressed = 1'b0;
                        knob_long    = 1'b0;
                        knob_press   = '0;
                    end else if (knob_press > LONG_START_MS && knob_press < LONG_END_MS) begin
                        knob_long = 1'b1;
                    end
                end
            end
            KIND_EDGE: begin
                if (knob_edges != 16'hFFFF)
                    knob_edges = knob_edges + 1'b1;
                knob_hold = it.run ? hold_run : hold_stop;
                step = (knob_rate < rate_thr) ? 32'(step_fine) : 32'(step_coarse);
                if (it.dir) begin
                    // an underflow counts as falling below the floor
                    if (step >= knob_sp || knob_sp - step <= lim_min)
                        knob_sp = lim_min;
                    else
                        knob_sp = SP_W'(knob_sp - step);
                end else begin
                    sum     = knob_sp + step;
                    knob_sp = (sum > lim_max) ? lim_max : sum[SP_W-1:0];
                end
            end
            KIND_WINDOW: begin
                prod       = knob_edges * 3;
                knob_rate  = (prod > 65535) ? 16'hFFFF : prod[SP_W-1:0];
                knob_edges = '0;
            end
            default: ;
        endcase
        res.setpoint    = knob_sp;
        res.long_press  = knob_long;
        res.knob_active = (knob_hold != 0);
        knob_results_due.push_back(res);
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        // keep the log short when the block is badly off
        if (err_count < REPORT_LINES)
            $display("%0t ns mismatch %s: got %0d expected %0d", $time, what, got, want);
        err_count++;
    endtask

    task automatic check_result(logic [OUT_DATA_W-1:0] beat);
        t_knob_result got, want;
        if (knob_results_due.size() == 0) begin
            report_mismatch("unexpected result beat", 32'(beat), 0);
            return;
        end
        want = knob_results_due.pop_front();
        got  = t_knob_result'(beat[$bits(t_knob_result)-1:0]);
        if (got.setpoint != want.setpoint)
            report_mismatch("setpoint", got.setpoint, want.setpoint);
        if (got.commit != want.commit)
            report_mismatch("commit", got.commit, want.commit);
        if (got.beep != want.beep)
            report_mismatch("beep", got.beep, want.beep);
        if (got.start_request != want.start_request)
            report_mismatch("start_request", got.start_request, want.start_request);
        if (got.stop_request != want.stop_request)
            report_mismatch("stop_request", got.stop_request, want.stop_request);
        if (got.long_press != want.long_press)
            report_mismatch("long_press", got.long_press, want.long_press);
        if (got.knob_active != want.knob_active)
            report_mismatch("knob_active", got.knob_active, want.knob_active);
    endtask

    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, 9);
    endfunction

    // sender: one item per beat, a drawn gap before each launch
    always @(posedge i_clk) begin : drive_items
        logic next_valid;
        next_valid = s_axis_tvalid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
            send_gap   = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                advance_knob(item_on_bus);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (items_to_send.size() != 0) begin
                    item_on_bus  = items_to_send.pop_front();
                    s_axis_tdata <= {5'b0, item_on_bus.run, item_on_bus.dir,
                                     item_on_bus.down, item_on_bus.tick};
                    s_axis_tuser <= item_on_bus.kind;
                    next_valid   = 1'b1;
                    send_gap     = draw_wait();
                end
            end
        end
        s_axis_tvalid <= next_valid;
    end

    // receiver: stalls a drawn number of cycles before each result beat
    always @(posedge i_clk) begin : collect_results
        logic next_ready;
        next_ready = m_axis_tready;
        if (!i_rst_n) begin
            next_ready = 1'b0;
            recv_stall = 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            check_result(m_axis_tdata);
            recv_stall = draw_wait();
            next_ready = (recv_stall == 0);
        end else if (!m_axis_tready) begin
            if (recv_stall > 0)
                recv_stall--;
            if (recv_stall == 0)
                next_ready = 1'b1;
        end
        m_axis_tready <= next_ready;
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL rotary_knob_setpoint_control_top");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_item(t_kind kind, int tick, bit down, bit dir, bit run);
        t_knob_item it;
        it.kind = kind;
        it.tick = tick[TICK_W-1:0];
        it.down = down;
        it.dir  = dir;
        it.run  = run;
        items_to_send.push_back(it);
    endtask

    // mostly button holds and knob turns with random content, a little junk
    task automatic add_random_item(int edge_w, int win_w);
        t_knob_item it;
        int unsigned r;
        r       = $urandom_range(0, 99);
        it.tick = TICK_W'($urandom);
        it.down = 1'($urandom);
        it.dir  = 1'($urandom);
        it.run  = gen_run;
        if (r < 4) begin
            it.kind = KIND_NONE;
            it.run  = 1'($urandom);
        end else if (r < 4 + win_w) begin
            it.kind = KIND_WINDOW;
        end else if (r < 4 + win_w + edge_w) begin
            it.kind = KIND_EDGE;
        end else begin
            it.kind = KIND_TICK;
            if ($urandom_range(0, 3) != 0)
                it.tick = TICK_W'($urandom_range(0, 40));
            if ($urandom_range(0, 7) == 0)
                gen_btn = !gen_btn;
            it.down = ($urandom_range(0, 19) == 0) ? !gen_btn : gen_btn;
        end
        if ($urandom_range(0, 29) == 0)
            gen_run = !gen_run;
        items_to_send.push_back(it);
    endtask

    task automatic set_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_SETPOINT_MIN:   lim_min     = val;
            REG_SETPOINT_MAX:   lim_max     = val;
            REG_FAST_THRESHOLD: rate_thr    = val;
            REG_FINE_STEP:      step_fine   = val[STEP_W-1:0];
            REG_COARSE_STEP:    step_coarse = val[STEP_W-1:0];
            REG_HOLD_RUNNING:   hold_run    = val[HOLD_W-1:0];
            REG_HOLD_STOPPED:   hold_stop   = val[HOLD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(int phase);
        t_knob_cfg c;
        case (phase)
            0: c = '{16'd100, 16'd2000, 16'd30, 10'd7, 10'd50, 13'd300, 13'd150};
            1: c = '{16'd0, 16'd65535, 16'd0, 10'd0, 10'd1023, 13'd8191, 13'd0};
            // floor above ceiling: each clamp acts on its own side
            2: c = '{16'd65535, 16'd0, 16'd65535, 10'd1023, 10'd0, 13'd0, 13'd8191};
            3: c = '{16'd40000, 16'd60000, 16'd9, 10'd512, 10'd1000, 13'd500, 13'd1000};
            default: begin
                c.lo     = SP_W'($urandom_range(0, 30000));
                c.hi     = SP_W'($urandom_range(30000, 65535));
                c.thr    = SP_W'($urandom_range(0, 120));
                c.fine   = STEP_W'($urandom);
                c.coarse = STEP_W'($urandom);
                c.hrun   = HOLD_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                                : $urandom_range(0, 600));
                c.hstop  = HOLD_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                                : $urandom_range(0, 600));
            end
        endcase
        set_register(REG_SETPOINT_MIN, c.lo);
        set_register(REG_SETPOINT_MAX, c.hi);
        set_register(REG_FAST_THRESHOLD, c.thr);
        set_register(REG_FINE_STEP, CFG_DATA_W'(c.fine));
        set_register(REG_COARSE_STEP, CFG_DATA_W'(c.coarse));
        set_register(REG_HOLD_RUNNING, CFG_DATA_W'(c.hrun));
        set_register(REG_HOLD_STOPPED, CFG_DATA_W'(c.hstop));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // the test holds off until every queued item is sent and its result has come back
    // checked on the falling edge so the bus and queues have settled
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (items_to_send.size() != 0 || knob_results_due.size() != 0 || s_axis_tvalid);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : run_test
        int edge_w, win_w;
        reset_knob();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part on reset register values
        add_item(KIND_TICK, 0, 0, 0, 0);
        add_item(KIND_NONE, 255, 1, 1, 1);
        add_item(KIND_EDGE, 0, 0, 0, 0);
        add_item(KIND_EDGE, 0, 0, 0, 1);
        add_item(KIND_EDGE, 0, 0, 1, 0);
        add_item(KIND_EDGE, 0, 0, 1, 0);      // step equals setpoint
        add_item(KIND_EDGE, 0, 0, 1, 1);      // would go below zero
        add_item(KIND_TICK, 0, 0, 0, 1);      // zero tick leaves the timer alone
        add_item(KIND_TICK, 200, 1, 0, 1);
        add_item(KIND_TICK, 0, 0, 0, 1);      // short release while running
        add_item(KIND_TICK, 100, 1, 0, 0);
        add_item(KIND_TICK, 0, 0, 0, 0);      // exactly 100 ms: no request
        add_item(KIND_TICK, 101, 1, 0, 0);
        add_item(KIND_TICK, 50, 0, 0, 0);     // short release while stopped
        add_item(KIND_EDGE, 0, 0, 0, 0);
        repeat (5) add_item(KIND_TICK, 255, 1, 0, 0);
        add_item(KIND_TICK, 225, 1, 0, 0);    // exactly 1500 ms: not latched yet
        add_item(KIND_TICK, 1, 1, 0, 0);      // latches long press
        add_item(KIND_TICK, 255, 1, 0, 0);    // press time frozen while latched
        add_item(KIND_TICK, 255, 0, 0, 1);    // release, hold runs out with beep
        add_item(KIND_WINDOW, 0, 0, 0, 0);
        wait_drained();

        for (int c = 0; c < CHUNKS; c++) begin
            if (c % 2 == 0)
                apply_setting(c / 2);
            quiet = (c % 4 == 3);
            case ($urandom_range(0, 2))
                0: edge_w = 10;
                1: edge_w = 35;
                default: edge_w = 60;
            endcase
            case ($urandom_range(0, 2))
                0: win_w = 2;
                1: win_w = 6;
                default: win_w = 15;
            endcase
            repeat (CHUNK_ITEMS) add_random_item(edge_w, win_w);
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (knob_results_due.size() != 0)
            report_mismatch("results never delivered", knob_results_due.size(), 0);
        if (err_count == 0)
            $display("PASS rotary_knob_setpoint_control_top");
        else
            $display("FAIL rotary_knob_setpoint_control_top");
        $finish;
    end

endmodule
